// ===== src/vn2d_pkg.sv =====
// Shared types, constants and register map of the 2D value noise sampler.
package vn2d_pkg;

  // Coordinate format
  localparam int unsigned FracBits = 16;
  localparam int unsigned FracShr  = (FracBits >= 16) ? (FracBits - 16) : 0;
  localparam int unsigned FracShl  = (FracBits < 16) ? (16 - FracBits) : 0;
  localparam logic [31:0] FracMask = 32'((64'd1 << FracBits) - 64'd1);

  // Corner hash constants
  localparam logic [31:0] HashMulX  = 32'd374761393;
  localparam logic [31:0] HashMulY  = 32'd668265263;
  localparam logic [31:0] HashMulS  = 32'd982451653;
  localparam logic [31:0] HashMulF  = 32'd1274126177;
  localparam logic [31:0] HashMulXY = 32'(64'd374761393 + 64'd668265263);
  localparam int unsigned HashShift = 13;

  // Q0.16 one and fade constants
  localparam logic [16:0] Q16One     = 17'd65536;
  localparam logic [20:0] FadeConst  = 21'd655360;
  localparam logic [17:0] CornerBias = 18'd65280;

  // Register map
  localparam int unsigned ApbAddrW = 3;
  localparam logic [ApbAddrW-3:0] RegIdxNoiseSeed = '0;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [16:0] noise_t;

endpackage

// ===== src/vn2d_if.sv =====
// Stream interfaces for coordinate requests and noise results.
interface vn2d_coord_if;
  import vn2d_pkg::*;
  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vn2d_noise_if;
  import vn2d_pkg::*;
  logic   valid;
  logic   ready;
  noise_t noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

// ===== src/value_noise_2d_sampler.sv =====
// Top level: pipelined 2D value noise sampler with APB seed register.
//
//  channel     | dir | handshake          | payload
//  ------------+-----+--------------------+-------------------------------
//  coord_in    | in  | valid / ready      | x_coord, y_coord (Q15.16)
//  noise_out   | out | valid / ready      | noise_value (x255, 8 frac bits)
//  apb         | in  | psel/penable/pready| noise_seed at byte address 0
//
//  Six register stages (input, products, hash sums and fade terms, corner
//  bytes and fade, x blend, y blend) carry each request to the output, and one
//  request is taken every cycle while the output is not stalled.
//  Each stage advances when it is empty or the stage after it advances, so
//  bubbles are squeezed out and a stalled output holds the items behind it.
//  Reset clears the valid bits and sets the seed to zero.
module value_noise_2d_sampler
  import vn2d_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  vn2d_coord_if.sink          coord_in,
  vn2d_noise_if.source        noise_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned NumStages = 6;

  // Blend a to b by a Q1.16 weight, product floored
  function automatic noise_t lerp_q16(noise_t a, noise_t b, logic [16:0] f);
    logic signed [17:0] fs;
    logic signed [17:0] diff;
    logic signed [35:0] prod;
    logic signed [19:0] sum;
    fs   = $signed({1'b0, f});
    diff = 18'(b) - 18'(a);
    prod = 36'(fs) * 36'(diff);
    sum  = 20'(a) + prod[35:16];
    return noise_t'(sum);
  endfunction

  // Map a hash byte to (2*b-255)*256
  function automatic noise_t corner_val(logic [7:0] b);
    logic [17:0] c;
    c = {1'b0, b, 9'b0} - CornerBias;
    return noise_t'(c[16:0]);
  endfunction

  // ------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------
  logic [31:0] seed_q;
  logic        cfg_we;
  logic        cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ApbAddrW-1:2] == RegIdxNoiseSeed);
  assign cfg_we  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? seed_q : '0;

  // Take the seed on a completed write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we) begin
      seed_q <= pwdata;
    end
  end

  // ------------------------------------------------------------------
  // Pipeline control
  // ------------------------------------------------------------------
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || noise_out.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign coord_in.ready  = en[0];
  assign noise_out.valid = v_q[NumStages-1];

  // Move valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= coord_in.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 0: capture the request
  // ------------------------------------------------------------------
  coord_t x0_q, y0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q <= coord_in.x_coord;
      y0_q <= coord_in.y_coord;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: cell products, Q0.16 fractions and their squares
  // ------------------------------------------------------------------
  logic [31:0] cx, cy;
  logic [31:0] fx_raw, fy_raw;
  logic [15:0] tx, ty;
  logic [31:0] tx_sq, ty_sq;
  logic [31:0] pxm_q, pym_q, psm_q;
  logic [15:0] tx1_q, ty1_q, tx2_q, ty2_q;

  always_comb begin
    cx     = 32'(x0_q >>> FracBits);
    cy     = 32'(y0_q >>> FracBits);
    fx_raw = 32'(x0_q) & FracMask;
    fy_raw = 32'(y0_q) & FracMask;
    tx     = 16'((fx_raw >> FracShr) << FracShl);
    ty     = 16'((fy_raw >> FracShr) << FracShl);
    tx_sq  = 32'(tx) * 32'(tx);
    ty_sq  = 32'(ty) * 32'(ty);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pxm_q <= 32'(cx * HashMulX);
      pym_q <= 32'(cy * HashMulY);
      psm_q <= 32'(seed_q * HashMulS);
      tx1_q <= tx;
      ty1_q <= ty;
      tx2_q <= tx_sq[31:16];
      ty2_q <= ty_sq[31:16];
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: corner hash sums, t cubed and the fade polynomial
  // ------------------------------------------------------------------
  logic [31:0] h00;
  logic [31:0] tx_cu, ty_cu;
  logic [20:0] px_sum, py_sum;
  logic [31:0] h_q [4];
  logic [15:0] tx3_q, ty3_q;
  logic [19:0] px_q, py_q;

  always_comb begin
    h00    = pxm_q + pym_q + psm_q;
    tx_cu  = 32'(tx2_q) * 32'(tx1_q);
    ty_cu  = 32'(ty2_q) * 32'(ty1_q);
    px_sum = 21'(6) * 21'(tx2_q) + FadeConst - 21'(15) * 21'(tx1_q);
    py_sum = 21'(6) * 21'(ty2_q) + FadeConst - 21'(15) * 21'(ty1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      h_q[0] <= h00;
      h_q[1] <= h00 + HashMulX;
      h_q[2] <= h00 + HashMulY;
      h_q[3] <= h00 + HashMulXY;
      tx3_q  <= tx_cu[31:16];
      ty3_q  <= ty_cu[31:16];
      px_q   <= px_sum[19:0];
      py_q   <= py_sum[19:0];
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: finish the hash (low byte only) and the fade
  // ------------------------------------------------------------------
  logic [7:0]  mix [4];
  logic [15:0] mixp [4];
  logic [35:0] fx_prod, fy_prod;
  logic [16:0] fx_d, fy_d;
  logic [7:0]  b_q [4];
  logic [16:0] fx3_q, fy3_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mix[c]  = h_q[c][7:0] ^ h_q[c][HashShift +: 8];
      mixp[c] = 16'(mix[c]) * 16'(HashMulF[7:0]);
    end
    fx_prod = 36'(tx3_q) * 36'(px_q);
    fy_prod = 36'(ty3_q) * 36'(py_q);
    fx_d    = (fx_prod[35:16] > 20'(Q16One)) ? Q16One : fx_prod[32:16];
    fy_d    = (fy_prod[35:16] > 20'(Q16One)) ? Q16One : fy_prod[32:16];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < 4; c++) begin
        b_q[c] <= mixp[c][7:0];
      end
      fx3_q <= fx_d;
      fy3_q <= fy_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: blend along x
  // ------------------------------------------------------------------
  noise_t      top_q, bot_q;
  logic [16:0] fy4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      top_q <= lerp_q16(corner_val(b_q[0]), corner_val(b_q[1]), fx3_q);
      bot_q <= lerp_q16(corner_val(b_q[2]), corner_val(b_q[3]), fx3_q);
      fy4_q <= fy3_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: blend along y into the output register
  // ------------------------------------------------------------------
  noise_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_q <= lerp_q16(top_q, bot_q, fy4_q);
    end
  end

  assign noise_out.noise_value = out_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_out.valid |-> ($signed(noise_out.noise_value) >= -17'sd65280 &&
                         $signed(noise_out.noise_value) <= 17'sd65280))
    else $error("noise value out of range");

  a_fade_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (fx3_q <= Q16One && fy3_q <= Q16One))
    else $error("fade weight above one");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q && !noise_out.ready) |-> !coord_in.ready)
    else $error("request taken into a full stalled pipeline");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !en[4]) |=> v_q[4])
    else $error("stalled x blend item dropped");

endmodule
